>>> hdl/arf_pkg.sv
// Shared types and constants for the alpha-blended rectangle fill unit.
// Used by arf_blend, arf_store, arf_ctrl and alpha_rect_fill_unit.
// No dependencies.
package arf_pkg;

	// Field widths.
	localparam int COORD_W = 11;
	localparam int POS_W   = 12;
	localparam int PIX_W   = 16;
	localparam int CNT_W   = 23;
	localparam int FADDR_W = 23;
	localparam int BASE_W  = 22;
	localparam int CIDX_W  = 2;

	// Command opcodes.
	localparam logic OP_FILL = 1'b0;
	localparam logic OP_READ = 1'b1;

	// Configuration register indexes.
	localparam logic [CIDX_W-1:0] CFG_X_LIMIT    = 2'd0;
	localparam logic [CIDX_W-1:0] CFG_Y_LIMIT    = 2'd1;
	localparam logic [CIDX_W-1:0] CFG_ROW_STRIDE = 2'd2;

	// Configuration values after reset.
	localparam logic [COORD_W-1:0] X_LIMIT_RST    = 11'd240;
	localparam logic [COORD_W-1:0] Y_LIMIT_RST    = 11'd320;
	localparam logic [COORD_W-1:0] ROW_STRIDE_RST = 11'd240;

	// Sequencer states.
	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_SETUP,
		ST_ROW,
		ST_PIX,
		ST_RDWT,
		ST_MUL,
		ST_WRB
	} arf_state_t;

	typedef struct packed {
		logic [COORD_W-1:0] x_limit;
		logic [COORD_W-1:0] y_limit;
		logic [COORD_W-1:0] row_stride;
	} arf_cfg_t;

	typedef struct packed {
		logic               opcode;
		logic [POS_W-1:0]   y_pos;
		logic [POS_W-1:0]   x_pos;
		logic [COORD_W-1:0] rect_height;
		logic [COORD_W-1:0] rect_width;
		logic [7:0]         red;
		logic [7:0]         green;
		logic [7:0]         blue;
		logic [7:0]         alpha;
	} arf_cmd_t;

	typedef struct packed {
		logic             done;
		logic [PIX_W-1:0] read_data;
		logic [CNT_W-1:0] pixels_written;
	} arf_result_t;

	typedef struct packed {
		logic               rd_en;
		logic               wr_en;
		logic [FADDR_W-1:0] addr;
		logic [PIX_W-1:0]   wdata;
	} arf_mem_req_t;

	typedef struct packed {
		logic        en;
		logic [7:0]  inv_alpha;
		logic [15:0] color_term;
	} arf_blend_req_t;

endpackage

>>> hdl/arf_blend.sv
// Two-stage blend unit: both bytes of a pixel word mixed with the fill color.
// Depends on arf_pkg for the request struct.
module arf_blend (
	input  logic                    clk,
	input  arf_pkg::arf_blend_req_t req,
	input  logic [15:0]             old_word,
	output logic [15:0]             new_word
);

	logic [15:0] prod_lo_s1;
	logic [15:0] prod_hi_s1;
	logic [16:0] sum_lo;
	logic [16:0] sum_hi;
	logic [16:0] rnd_lo;
	logic [16:0] rnd_hi;

	// Stage one: old byte times the inverse weight.
	always_ff @(posedge clk) begin
		if (req.en) begin
			prod_lo_s1 <= 16'(old_word[7:0]) * 16'(req.inv_alpha);
			prod_hi_s1 <= 16'(old_word[15:8]) * 16'(req.inv_alpha);
		end
	end

	// Stage two: add the color term and divide by 255.
	// The sum never exceeds 255*255, where (s + 1 + (s >> 8)) >> 8 is exact.
	always_comb begin
		sum_lo   = {1'b0, prod_lo_s1} + {1'b0, req.color_term};
		sum_hi   = {1'b0, prod_hi_s1} + {1'b0, req.color_term};
		rnd_lo   = sum_lo + 17'd1 + (sum_lo >> 8);
		rnd_hi   = sum_hi + 17'd1 + (sum_hi >> 8);
		new_word = {rnd_hi[15:8], rnd_lo[15:8]};
	end

endmodule

>>> hdl/arf_store.sv
// Pixel frame store: single-port memory with registered read data.
// Depends on arf_pkg for the access request struct.
module arf_store #(
	parameter int STORE_DEPTH = 131072
) (
	input  logic                  clk,
	input  arf_pkg::arf_mem_req_t req,
	output logic [15:0]           rdata
);

	localparam int AW = $clog2(STORE_DEPTH);

	logic [15:0] mem [STORE_DEPTH];
	logic [15:0] rdata_q;

	// One write and one read per cycle, each under its own enable.
	always_ff @(posedge clk) begin
		if (req.wr_en) begin
			mem[req.addr[AW-1:0]] <= req.wdata;
		end
		if (req.rd_en) begin
			rdata_q <= mem[req.addr[AW-1:0]];
		end
	end

	assign rdata = rdata_q;

endmodule

>>> hdl/arf_ctrl.sv
// Sequencer: store clear, clip setup, row/column walk, pixel read and read-modify-write.
// Depends on arf_pkg; drives arf_store and arf_blend through request structs.
module arf_ctrl #(
	parameter int STORE_DEPTH = 131072,
	parameter int MAX_RES     = 1024
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  arf_pkg::arf_cfg_t       cfg,
	input  logic                    cmd_valid,
	input  arf_pkg::arf_cmd_t       cmd,
	output logic                    cmd_ready,
	input  logic                    res_ready,
	output arf_pkg::arf_result_t    res,
	output arf_pkg::arf_mem_req_t   mem_req,
	input  logic [15:0]             mem_rdata,
	output arf_pkg::arf_blend_req_t blend_req,
	input  logic [15:0]             blend_word
);

	localparam int AW = $clog2(STORE_DEPTH);
	localparam logic [AW-1:0] CLR_LAST = AW'(STORE_DEPTH - 1);
	localparam logic [arf_pkg::FADDR_W-1:0] DEPTH_W = arf_pkg::FADDR_W'(STORE_DEPTH);
	localparam logic [12:0] MAX_RES_W = 13'(MAX_RES);

	arf_pkg::arf_state_t state_q, state_d;

	logic [AW-1:0]                    clr_q;
	arf_pkg::arf_cmd_t                cmd_q;
	logic [arf_pkg::COORD_W-1:0]      i_q, j_q, x0_q, x1_q, y1_q;
	logic [arf_pkg::BASE_W-1:0]       base_q;
	logic [7:0]                       inv_a_q;
	logic [15:0]                      va_q;
	logic [arf_pkg::PIX_W-1:0]        data_q;
	logic [arf_pkg::CNT_W-1:0]        cnt_q;

	logic [arf_pkg::COORD_W-1:0]      xl, yl, x0, y0, x1, y1;
	logic signed [12:0]               x_end, y_end;
	logic                             empty, rd_neg;
	logic [7:0]                       packed_color;
	logic [arf_pkg::FADDR_W-1:0]      addr_sum;
	logic                             in_store;
	logic [arf_pkg::COORD_W:0]        j_inc, i_inc;
	logic                             last_col, last_row;
	logic                             done_d;
	logic                             hold;

	// Clip bounds for a fill, from the latched command.
	always_comb begin
		xl = ({2'b00, cfg.x_limit} > MAX_RES_W) ? MAX_RES_W[10:0] : cfg.x_limit;
		yl = ({2'b00, cfg.y_limit} > MAX_RES_W) ? MAX_RES_W[10:0] : cfg.y_limit;
		x0 = cmd_q.x_pos[11] ? '0 : cmd_q.x_pos[10:0];
		y0 = cmd_q.y_pos[11] ? '0 : cmd_q.y_pos[10:0];
		x_end = $signed({cmd_q.x_pos[11], cmd_q.x_pos}) + $signed({2'b00, cmd_q.rect_width});
		y_end = $signed({cmd_q.y_pos[11], cmd_q.y_pos}) + $signed({2'b00, cmd_q.rect_height});
		if (x_end[12]) begin
			x1 = '0;
		end else if (x_end > $signed({2'b00, xl})) begin
			x1 = xl;
		end else begin
			x1 = x_end[10:0];
		end
		if (y_end[12]) begin
			y1 = '0;
		end else if (y_end > $signed({2'b00, yl})) begin
			y1 = yl;
		end else begin
			y1 = y_end[10:0];
		end
		empty        = (x0 >= x1) || (y0 >= y1);
		rd_neg       = cmd_q.x_pos[11] || cmd_q.y_pos[11];
		packed_color = {cmd_q.red[7:5], cmd_q.blue[7:6], cmd_q.green[7:5]};
	end

	// Current pixel address and walk position.
	always_comb begin
		addr_sum = {1'b0, base_q} + arf_pkg::FADDR_W'(j_q);
		in_store = addr_sum < DEPTH_W;
		j_inc    = {1'b0, j_q} + 12'd1;
		i_inc    = {1'b0, i_q} + 12'd1;
		last_col = j_inc >= {1'b0, x1_q};
		last_row = i_inc >= {1'b0, y1_q};
	end

	// State register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= arf_pkg::ST_CLEAR;
			clr_q   <= '0;
		end else begin
			state_q <= state_d;
			if (state_q == arf_pkg::ST_CLEAR) begin
				clr_q <= clr_q + AW'(1);
			end
		end
	end

	// Next state, memory and blend requests, result.
	always_comb begin
		state_d              = state_q;
		mem_req              = '0;
		blend_req.en         = 1'b0;
		blend_req.inv_alpha  = inv_a_q;
		blend_req.color_term = va_q;
		done_d               = 1'b0;
		cmd_ready            = (state_q == arf_pkg::ST_IDLE);
		case (state_q)
			arf_pkg::ST_CLEAR: begin
				mem_req.wr_en = 1'b1;
				mem_req.addr  = arf_pkg::FADDR_W'(clr_q);
				if (clr_q == CLR_LAST) begin
					state_d = arf_pkg::ST_IDLE;
				end
			end
			arf_pkg::ST_IDLE: begin
				if (cmd_valid) begin
					state_d = arf_pkg::ST_SETUP;
				end
			end
			arf_pkg::ST_SETUP: begin
				if (cmd_q.opcode == arf_pkg::OP_READ) begin
					if (rd_neg) begin
						done_d = 1'b1;
					end else begin
						state_d = arf_pkg::ST_ROW;
					end
				end else if (empty) begin
					done_d = 1'b1;
				end else begin
					state_d = arf_pkg::ST_ROW;
				end
			end
			arf_pkg::ST_ROW: begin
				state_d = arf_pkg::ST_PIX;
			end
			arf_pkg::ST_PIX: begin
				mem_req.addr = addr_sum;
				if (cmd_q.opcode == arf_pkg::OP_READ) begin
					if (in_store) begin
						mem_req.rd_en = 1'b1;
						state_d       = arf_pkg::ST_RDWT;
					end else begin
						done_d = 1'b1;
					end
				end else if (in_store) begin
					mem_req.rd_en = 1'b1;
					state_d       = arf_pkg::ST_MUL;
				end else if (last_col) begin
					if (last_row) begin
						done_d = 1'b1;
					end else begin
						state_d = arf_pkg::ST_ROW;
					end
				end
			end
			arf_pkg::ST_RDWT: begin
				done_d = 1'b1;
			end
			arf_pkg::ST_MUL: begin
				blend_req.en = 1'b1;
				state_d      = arf_pkg::ST_WRB;
			end
			arf_pkg::ST_WRB: begin
				mem_req.wr_en = 1'b1;
				mem_req.addr  = addr_sum;
				mem_req.wdata = blend_word;
				if (last_col) begin
					if (last_row) begin
						done_d = 1'b1;
					end else begin
						state_d = arf_pkg::ST_ROW;
					end
				end else begin
					state_d = arf_pkg::ST_PIX;
				end
			end
			default: begin
				state_d = arf_pkg::ST_IDLE;
			end
		endcase
		// A finished command parks here until the output register has room.
		// The read word and the last pixel's count are taken as they arrive.
		res.done           = 1'b0;
		res.read_data      = (state_q == arf_pkg::ST_RDWT) ? mem_rdata : data_q;
		res.pixels_written = (state_q == arf_pkg::ST_WRB) ? cnt_q + arf_pkg::CNT_W'(1)
			: cnt_q;
		hold               = done_d && !res_ready;
		if (done_d) begin
			if (res_ready) begin
				res.done = 1'b1;
				state_d  = arf_pkg::ST_IDLE;
			end else begin
				state_d = state_q;
			end
		end
	end

	// Datapath registers; frozen while a finished command waits.
	always_ff @(posedge clk) begin
		if (!hold) begin
			case (state_q)
				arf_pkg::ST_IDLE: begin
					cmd_q  <= cmd;
					data_q <= '0;
					cnt_q  <= '0;
				end
				arf_pkg::ST_SETUP: begin
					inv_a_q <= ~cmd_q.alpha;
					va_q    <= 16'(packed_color) * 16'(cmd_q.alpha);
					x0_q    <= x0;
					x1_q    <= x1;
					y1_q    <= y1;
					if (cmd_q.opcode == arf_pkg::OP_READ) begin
						i_q <= cmd_q.y_pos[10:0];
						j_q <= cmd_q.x_pos[10:0];
					end else begin
						i_q <= y0;
						j_q <= x0;
					end
				end
				arf_pkg::ST_ROW: begin
					base_q <= arf_pkg::BASE_W'(i_q) * arf_pkg::BASE_W'(cfg.row_stride);
				end
				arf_pkg::ST_PIX: begin
					if (cmd_q.opcode == arf_pkg::OP_FILL && !in_store && !last_col) begin
						j_q <= j_inc[10:0];
					end else if (cmd_q.opcode == arf_pkg::OP_FILL && !in_store) begin
						j_q <= x0_q;
						i_q <= i_inc[10:0];
					end
				end
				arf_pkg::ST_RDWT: begin
					data_q <= mem_rdata;
				end
				arf_pkg::ST_WRB: begin
					cnt_q <= cnt_q + arf_pkg::CNT_W'(1);
					if (last_col) begin
						j_q <= x0_q;
						i_q <= i_inc[10:0];
					end else begin
						j_q <= j_inc[10:0];
					end
				end
				default: begin
				end
			endcase
		end
	end

`ifndef SYNTHESIS
	// The store port never reads and writes in the same cycle.
	assert property (@(posedge clk) disable iff (!arst_n)
		!(mem_req.rd_en && mem_req.wr_en))
		else $error("store read and write in the same cycle");

	// Every store access stays inside the store.
	assert property (@(posedge clk) disable iff (!arst_n)
		(mem_req.rd_en || mem_req.wr_en) |-> (mem_req.addr < DEPTH_W))
		else $error("store access past its depth");

	// A result is handed over only when the output register can take it.
	assert property (@(posedge clk) disable iff (!arst_n)
		res.done |-> res_ready)
		else $error("result handed over while output register full");

	// A blended write follows the blend stage of the same pixel, or waits in place.
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == arf_pkg::ST_WRB) |->
		($past(state_q) == arf_pkg::ST_MUL || $past(state_q) == arf_pkg::ST_WRB))
		else $error("pixel write without a preceding blend stage");

	// No command is taken during the clearing pass.
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == arf_pkg::ST_CLEAR) |-> !cmd_ready)
		else $error("command accepted while clearing the store");
`endif

endmodule

>>> hdl/alpha_rect_fill_unit.sv
// Top level of the alpha-blended rectangle fill unit: ports, configuration
// registers and output register. Depends on arf_pkg, arf_ctrl, arf_store, arf_blend.
//
// Usage:
//   Input channel: one beat carries a command (in_valid, in_stall). Opcode fill
//   blends one packed color into every clipped pixel of a rectangle; opcode read
//   returns one pixel word. Output channel: one beat per command (out_valid,
//   out_stall) with read_data and pixels_written.
//   Configuration: cfg_we writes cfg_data into register cfg_index (x_limit,
//   y_limit, row_stride) at the clock edge; write only while no command is open.
// Timing:
//   After reset the store is cleared, one word per cycle, over all STORE_DEPTH words;
//   in_stall stays high during that pass. Configuration writes are taken then too.
//   A read's result follows setup, row, pixel and read-wait states after its beat;
//   a negative coordinate answers from setup, an address past the store from the
//   pixel state. A fill takes setup, then a row state per clipped row and, per pixel
//   inside the store, read, multiply and write on the single store port and the
//   blend unit; a pixel past the store takes only the pixel state, and an empty or
//   fully clipped fill answers from setup. The sequencer then goes back to idle.
//   One command is worked on at a time. The result sits in an output register, so
//   the next command is accepted while it waits; a stalled receiver holds the
//   finished command in the sequencer only once the output register is full.
module alpha_rect_fill_unit #(
	parameter int STORE_DEPTH = 131072,
	parameter int MAX_RES     = 1024
) (
	input  logic        clk,
	input  logic        arst_n,
	// Command channel.
	input  logic        in_valid,
	output logic        in_stall,
	input  logic        opcode,
	input  logic [11:0] y_pos,
	input  logic [11:0] x_pos,
	input  logic [10:0] rect_height,
	input  logic [10:0] rect_width,
	input  logic [7:0]  red,
	input  logic [7:0]  green,
	input  logic [7:0]  blue,
	input  logic [7:0]  alpha,
	// Result channel.
	output logic        out_valid,
	input  logic        out_stall,
	output logic [15:0] read_data,
	output logic [22:0] pixels_written,
	// Configuration write port.
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [10:0] cfg_data
);

	arf_pkg::arf_cfg_t       cfg_q;
	arf_pkg::arf_cmd_t       cmd;
	arf_pkg::arf_result_t    res;
	arf_pkg::arf_mem_req_t   mem_req;
	arf_pkg::arf_blend_req_t blend_req;
	logic                    cmd_ready;
	logic                    res_ready;
	logic [15:0]             mem_rdata;
	logic [15:0]             blend_word;
	logic                    out_valid_q;
	logic [15:0]             read_data_q;
	logic [22:0]             pixels_written_q;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.x_limit    <= arf_pkg::X_LIMIT_RST;
			cfg_q.y_limit    <= arf_pkg::Y_LIMIT_RST;
			cfg_q.row_stride <= arf_pkg::ROW_STRIDE_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				arf_pkg::CFG_X_LIMIT:    cfg_q.x_limit    <= cfg_data;
				arf_pkg::CFG_Y_LIMIT:    cfg_q.y_limit    <= cfg_data;
				arf_pkg::CFG_ROW_STRIDE: cfg_q.row_stride <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	// Command beat.
	always_comb begin
		cmd.opcode      = opcode;
		cmd.y_pos       = y_pos;
		cmd.x_pos       = x_pos;
		cmd.rect_height = rect_height;
		cmd.rect_width  = rect_width;
		cmd.red         = red;
		cmd.green       = green;
		cmd.blue        = blue;
		cmd.alpha       = alpha;
	end

	assign in_stall = !cmd_ready;

	arf_ctrl #(
		.STORE_DEPTH (STORE_DEPTH),
		.MAX_RES     (MAX_RES)
	) u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg_q),
		.cmd_valid  (in_valid),
		.cmd        (cmd),
		.cmd_ready  (cmd_ready),
		.res_ready  (res_ready),
		.res        (res),
		.mem_req    (mem_req),
		.mem_rdata  (mem_rdata),
		.blend_req  (blend_req),
		.blend_word (blend_word)
	);

	arf_store #(
		.STORE_DEPTH (STORE_DEPTH)
	) u_store (
		.clk   (clk),
		.req   (mem_req),
		.rdata (mem_rdata)
	);

	arf_blend u_blend (
		.clk      (clk),
		.req      (blend_req),
		.old_word (mem_rdata),
		.new_word (blend_word)
	);

	// Output register: free when empty or when its beat is taken this cycle.
	assign res_ready = !out_valid_q || !out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_ready) begin
			out_valid_q <= res.done;
		end
	end

	always_ff @(posedge clk) begin
		if (res.done) begin
			read_data_q      <= res.read_data;
			pixels_written_q <= res.pixels_written;
		end
	end

	assign out_valid      = out_valid_q;
	assign read_data      = read_data_q;
	assign pixels_written = pixels_written_q;

endmodule
